>>> rtl/cs_pkg.sv
// Shared constants, types and helpers for the cosine similarity block.
package cs_pkg;
	localparam int MAX_ELEMENTS_DEF  = 1024;
	localparam int ELEMENT_WIDTH_DEF = 16;
	localparam int IN_WIDTH          = 16;
	localparam int SIM_WIDTH         = 16;
	localparam int Q_BITS            = 15;
	localparam int ONE_Q14           = 16384;
	localparam int JOB_DEPTH         = 2;

	// Flags of the job handed from the accumulator to the evaluator.
	typedef struct packed {
		logic zero;
		logic ovf;
	} job_flags_t;
endpackage

>>> rtl/cs_accum.sv
// Front end: accumulates dot product and squared norms, emits a job per vector.
module cs_accum #(
	parameter int MAX_ELEMENTS  = cs_pkg::MAX_ELEMENTS_DEF,
	parameter int ELEMENT_WIDTH = cs_pkg::ELEMENT_WIDTH_DEF,
	parameter int SUM_BITS      = 2 * ELEMENT_WIDTH + 9
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic signed [cs_pkg::IN_WIDTH-1:0]  a_value,
	input  logic signed [cs_pkg::IN_WIDTH-1:0]  b_value,
	input  logic                                last_element,
	output logic                                job_valid,
	output logic signed [SUM_BITS:0]            job_dot,
	output logic        [SUM_BITS-1:0]          job_na,
	output logic        [SUM_BITS-1:0]          job_nb,
	output cs_pkg::job_flags_t                  job_flags
);
	import cs_pkg::*;
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int PW = 2 * ELEMENT_WIDTH;
	localparam logic signed [SUM_BITS+1:0] DMAX = (SUM_BITS+2)'((64'd1 << SUM_BITS) - 64'd1);
	localparam logic signed [SUM_BITS+1:0] DMIN = -DMAX - (SUM_BITS+2)'(1);
	localparam logic [SUM_BITS:0] NMAX = (SUM_BITS+1)'((64'd1 << SUM_BITS) - 64'd1);

	logic signed [ELEMENT_WIDTH-1:0] a_e, b_e;
	logic signed [PW-1:0] ab_s1, aa_s1, bb_s1;
	logic v_s1, last_s1, ovf_s1;
	logic signed [SUM_BITS:0] dot_q;
	logic [SUM_BITS-1:0] na_q, nb_q;
	logic [CW-1:0] cnt_q;
	logic ovf_q;
	logic signed [SUM_BITS+1:0] dsum;
	logic [SUM_BITS:0] asum, bsum;
	logic signed [SUM_BITS:0] dot_n;
	logic [SUM_BITS-1:0] na_n, nb_n;
	logic sat;

	assign a_e = a_value[ELEMENT_WIDTH-1:0];
	assign b_e = b_value[ELEMENT_WIDTH-1:0];

	// Stage 1: multiply and check the pair count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			cnt_q <= '0;
		end else begin
			v_s1 <= in_valid;
			if (in_valid) begin
				ab_s1 <= PW'(a_e) * PW'(b_e);
				aa_s1 <= PW'(a_e) * PW'(a_e);
				bb_s1 <= PW'(b_e) * PW'(b_e);
				last_s1 <= last_element;
				ovf_s1 <= (int'(cnt_q) >= MAX_ELEMENTS);
				if (last_element) cnt_q <= '0;
				else if (int'(cnt_q) < MAX_ELEMENTS) cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	assign dsum = (SUM_BITS+2)'(dot_q) + (SUM_BITS+2)'(ab_s1);
	assign asum = (SUM_BITS+1)'(na_q) + (SUM_BITS+1)'($unsigned(aa_s1));
	assign bsum = (SUM_BITS+1)'(nb_q) + (SUM_BITS+1)'($unsigned(bb_s1));

	always_comb begin
		sat = 1'b0;
		if (dsum > DMAX) begin dot_n = DMAX[SUM_BITS:0]; sat = 1'b1; end
		else if (dsum < DMIN) begin dot_n = DMIN[SUM_BITS:0]; sat = 1'b1; end
		else dot_n = dsum[SUM_BITS:0];
		if (asum > NMAX) begin na_n = NMAX[SUM_BITS-1:0]; sat = 1'b1; end
		else na_n = asum[SUM_BITS-1:0];
		if (bsum > NMAX) begin nb_n = NMAX[SUM_BITS-1:0]; sat = 1'b1; end
		else nb_n = bsum[SUM_BITS-1:0];
	end

	// Stage 2: saturating accumulate; hand the finished sums to the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0; na_q <= '0; nb_q <= '0; ovf_q <= 1'b0;
			job_valid <= 1'b0;
		end else begin
			job_valid <= v_s1 && last_s1;
			if (v_s1) begin
				if (last_s1) begin
					job_dot <= dot_n; job_na <= na_n; job_nb <= nb_n;
					job_flags.zero <= (na_n == '0) || (nb_n == '0);
					job_flags.ovf <= ovf_q | ovf_s1 | sat;
					dot_q <= '0; na_q <= '0; nb_q <= '0; ovf_q <= 1'b0;
				end else begin
					dot_q <= dot_n; na_q <= na_n; nb_q <= nb_n;
					ovf_q <= ovf_q | ovf_s1 | sat;
				end
			end
		end
	end
endmodule

>>> rtl/cs_eval.sv
// Back end: restoring bit search for q with q^2*na*nb <= dot^2*2^28.
module cs_eval #(
	parameter int SUM_BITS = 2 * cs_pkg::ELEMENT_WIDTH_DEF + 9
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [SUM_BITS:0]             dot,
	input  logic        [SUM_BITS-1:0]           na,
	input  logic        [SUM_BITS-1:0]           nb,
	input  cs_pkg::job_flags_t                   flags,
	output logic                                 busy,
	output logic                                 done,
	output logic signed [cs_pkg::SIM_WIDTH-1:0]  sim,
	output cs_pkg::job_flags_t                   flags_out
);
	import cs_pkg::*;
	localparam int MB = SUM_BITS + 1;
	localparam int PB = 2 * SUM_BITS;
	localparam int RB = 2 * MB + 28;
	localparam int LW = RB + 32;
	localparam int HB = SUM_BITS / 2 + 1;

	typedef enum logic [2:0] {S_IDLE, S_MA, S_MB, S_MC, S_MD, S_TRY, S_CMP, S_DONE} st_t;
	st_t st_q;
	logic [MB-1:0] mag_q;
	logic [SUM_BITS-1:0] na_q, nb_q;
	logic [PB-1:0] prod_q;
	logic [RB-1:0] rhs_q;
	logic [LW-1:0] lhs_q, t_q, qp_q, qp2_q;
	logic [Q_BITS:0] q_q, c;
	logic [3:0] bit_q;
	logic neg_q;
	logic [HB-1:0] lo_a, lo_m;
	logic [SUM_BITS-HB-1:0] hi_a;
	logic [MB-HB-1:0] hi_m;

	assign c = q_q | (Q_BITS+1)'(1) << bit_q;
	assign lo_a = na_q[HB-1:0];
	assign hi_a = na_q[SUM_BITS-1:HB];
	assign lo_m = mag_q[HB-1:0];
	assign hi_m = mag_q[MB-1:HB];

	// Wide products are built from half-width partial products over several states.
	// The search keeps q*P and q^2*P, so each trial needs only shifts and adds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				S_IDLE: if (start) begin
					mag_q <= dot[SUM_BITS] ? $unsigned(-dot) : $unsigned(dot);
					neg_q <= dot[SUM_BITS];
					na_q <= na; nb_q <= nb; flags_out <= flags;
					q_q <= '0; bit_q <= 4'(Q_BITS);
					qp_q <= '0; qp2_q <= '0;
					st_q <= flags.zero ? S_DONE : S_MA;
				end
				S_MA: begin
					prod_q <= PB'(lo_a) * PB'(nb_q);
					rhs_q <= (RB'(lo_m) * RB'(mag_q)) << 28;
					st_q <= S_MB;
				end
				S_MB: begin
					prod_q <= prod_q + ((PB'(hi_a) * PB'(nb_q)) << HB);
					st_q <= S_MC;
				end
				S_MC: begin
					rhs_q <= rhs_q + ((RB'(hi_m) * RB'(mag_q)) << (HB + 28));
					st_q <= S_TRY;
				end
				S_TRY: begin
					t_q <= qp2_q + (qp_q << (5'(bit_q) + 5'd1));
					st_q <= S_MD;
				end
				S_MD: begin
					lhs_q <= t_q + (LW'(prod_q) << {bit_q, 1'b0});
					st_q <= S_CMP;
				end
				S_CMP: begin
					if (lhs_q <= LW'(rhs_q)) begin
						q_q <= c;
						qp2_q <= lhs_q;
						qp_q <= qp_q + (LW'(prod_q) << bit_q);
					end
					if (bit_q == '0) st_q <= S_DONE;
					else begin bit_q <= bit_q - 4'd1; st_q <= S_TRY; end
				end
				S_DONE: begin
					done <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	logic [Q_BITS:0] qc;
	assign qc = (flags_out.zero) ? '0 :
	            (q_q > (Q_BITS+1)'(ONE_Q14)) ? (Q_BITS+1)'(ONE_Q14) : q_q;
	assign sim = neg_q ? -SIM_WIDTH'(qc) : SIM_WIDTH'(qc);
	assign busy = (st_q != S_IDLE);
endmodule

>>> rtl/cosine_similarity_top.sv
// Top level of the streaming cosine similarity block.
//
// Input channel: a queue write port (push/full) carrying one element pair
// (a_value, b_value) and a last_element marker per word. A word is taken on
// every cycle while full is low; full rises once two finished vectors are
// waiting in the job queue or still travel through the front end.
// Result channel: a queue read port (empty/pop). While empty is low the oldest
// result (similarity in Q1.14, zero_vector, length_overflow) is shown; pop takes it.
// From the edge that takes the last pair, a result passes the front-end registers
// and the job queue, the start in S_IDLE, the wide products (S_MA, S_MB, S_MC),
// the quotient search (S_TRY, S_MD and S_CMP for each bit), S_DONE and the
// result queue. A zero vector skips the search. The back end takes no new vector
// until it has finished the last, so short vectors back up behind it while pairs
// still arrive at one per cycle, until full rises.
// A two-entry job queue sits between front and back end, and a two-entry
// result queue sits at the output. When the receiver stalls, results wait in
// the result queue, the back end holds off starting, the job queue fills and
// full stalls the input. Reset clears all sums and both queues.
module cosine_similarity_top #(
	parameter int MAX_ELEMENTS  = cs_pkg::MAX_ELEMENTS_DEF,
	parameter int ELEMENT_WIDTH = cs_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [cs_pkg::IN_WIDTH-1:0]   a_value,
	input  logic signed [cs_pkg::IN_WIDTH-1:0]   b_value,
	input  logic                                 last_element,
	output logic                                 empty,
	input  logic                                 pop,
	output logic signed [cs_pkg::SIM_WIDTH-1:0]  similarity,
	output logic                                 zero_vector,
	output logic                                 length_overflow
);
	import cs_pkg::*;
	localparam int SB = 2 * ELEMENT_WIDTH + 9;
	localparam int JW = (SB + 1) + 2 * SB + 2;
	localparam int RW = SIM_WIDTH + 2;

	logic jv;
	logic signed [SB:0] jd;
	logic [SB-1:0] ja, jb;
	job_flags_t jf, ef, ofl;
	logic [JW-1:0] jq_q [JOB_DEPTH];
	logic [1:0] jcnt_q, rcnt_q, infl_q;
	logic jrd_q, rrd_q, jwr_q, rwr_q;
	logic [JW-1:0] jhead;
	logic busy, done, start;
	logic signed [SIM_WIDTH-1:0] esim;
	logic [RW-1:0] rq_q [JOB_DEPTH];
	logic [RW-1:0] rhead;
	logic in_acc, out_acc, rspace;

	// Hold push off once every job slot is taken by a stored job or by a
	// last word still in the front-end pipeline.
	assign full = (3'(jcnt_q) + 3'(infl_q)) >= 3'(JOB_DEPTH);
	assign in_acc = push && !full;

	cs_accum #(.MAX_ELEMENTS(MAX_ELEMENTS), .ELEMENT_WIDTH(ELEMENT_WIDTH), .SUM_BITS(SB)) u_acc (
		.clk, .arst_n, .in_valid(in_acc), .a_value, .b_value, .last_element,
		.job_valid(jv), .job_dot(jd), .job_na(ja), .job_nb(jb), .job_flags(jf)
	);

	// Job queue: a two-entry ring; an entry lost here would drop a result.
	// Reserve space at accept time by counting in-flight last words.
	assign jhead = jq_q[jrd_q];
	assign rspace = (rcnt_q + 2'(busy)) < 2'd2;
	assign start = (jcnt_q != 2'd0) && !busy && !done && rspace;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jcnt_q <= '0; jrd_q <= 1'b0; jwr_q <= 1'b0; infl_q <= '0;
		end else begin
			if (jv) begin
				jq_q[jwr_q] <= {jd, ja, jb, jf};
				jwr_q <= ~jwr_q;
			end
			if (start) jrd_q <= ~jrd_q;
			jcnt_q <= jcnt_q + 2'(jv) - 2'(start);
			infl_q <= infl_q + 2'(in_acc && last_element) - 2'(jv);
		end
	end

	cs_eval #(.SUM_BITS(SB)) u_eval (
		.clk, .arst_n, .start,
		.dot(jhead[JW-1 -: SB+1]), .na(jhead[2*SB+1:SB+2]), .nb(jhead[SB+1:2]),
		.flags(jhead[1:0]), .busy, .done, .sim(esim), .flags_out(ef)
	);

	// Result queue; drop the head on pop.
	assign empty = (rcnt_q == 2'd0);
	assign out_acc = pop && !empty;
	assign rhead = rq_q[rrd_q];
	assign ofl = rhead[1:0];
	assign similarity = rhead[RW-1:2];
	assign zero_vector = ofl.zero;
	assign length_overflow = ofl.ovf;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= '0; rrd_q <= 1'b0; rwr_q <= 1'b0;
		end else begin
			if (done) begin
				rq_q[rwr_q] <= {esim, ef};
				rwr_q <= ~rwr_q;
			end
			if (out_acc) rrd_q <= ~rrd_q;
			rcnt_q <= rcnt_q + 2'(done) - 2'(out_acc);
		end
	end
endmodule

>>> rtl/cs_checker.sv
// Port-level checker for the cosine similarity block, with its bind.
module cs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [15:0] similarity,
	input logic        zero_vector,
	input logic        length_overflow
);
	a_zero_sim: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && zero_vector |-> similarity == 16'd0) else $error("zero vector sim");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ($signed(similarity) <= 16384 && $signed(similarity) >= -16384))
		else $error("sim range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(similarity)) else $error("head changed");
	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(zero_vector) && $stable(length_overflow))
		else $error("head flags changed");
endmodule

bind cosine_similarity_top cs_checker u_chk (
	.clk, .arst_n, .empty, .pop, .similarity, .zero_vector, .length_overflow
);
